// ===== hw/rtl/pffwl_pkg.sv =====
// Package with the shared types and constants of the per-flow fixed-window limiter.
`timescale 1ns / 1ps
package pffwl_pkg;

  // Number of flow slots, one cell per slot.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths.
  localparam int PORT_W   = 8;
  localparam int VLAN_W   = 12;
  localparam int TICK_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int WINDOW_W = 20;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // Special VLAN ids and count limit.
  localparam logic [VLAN_W-1:0]  VLAN_NONE     = 12'd0;
  localparam logic [VLAN_W-1:0]  VLAN_RESERVED = 12'd4095;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

  // Register reset values.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd1000;
  localparam logic [COUNT_W-1:0]  MAX_RESET    = 16'd15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS  = 2'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PASS     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_VLAN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Lookup token that walks down the row of cells.
  typedef struct packed {
    logic                active;
    logic                found;
    logic                free_seen;
    logic [IDX_W-1:0]    free_idx;
    logic [PORT_W-1:0]   port;
    logic [VLAN_W-1:0]   vlan;
    logic [TICK_W-1:0]   now;
    logic                drop;
    logic [STATUS_W-1:0] status;
  } tok_t;

  // New-entry write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    logic [TICK_W-1:0] now;
  } alloc_t;

endpackage

// ===== hw/rtl/per_flow_fixed_window_limiter_unit.sv =====
// Top level of the per-flow fixed-window limiter: input, row of slot cells, result.
//
// Usage: each input transaction (port_id, vlan_tag, now_ticks) is one packet
// arrival. One output transaction (drop, status) comes back per input, in order.
// The lookup token walks a row of TABLE_ENTRIES cells, one cell per cycle;
// the matching cell updates its count and window on the way. After the row,
// a miss either allocates the lowest free slot or reports invalid VLAN or
// table full. After the row the token goes to a holding register, then the
// result to the output register; in_ready returns in the same cycle as the
// result appears, so a new input is taken only after the last one is done.
// The configuration channel is always ready; index 0 is window_ticks,
// index 1 is max_packets, other indexes are ignored. Write it only while idle.
// Reset (synchronous rst) clears all slot valid bits at once and loads the
// register defaults. When the receiver stalls, the next finished lookup waits
// in a holding register and its new entry is not written until the result
// ahead of it is taken.
`timescale 1ns / 1ps
module per_flow_fixed_window_limiter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pffwl_pkg::PORT_W-1:0]    port_id,
  input  logic [pffwl_pkg::VLAN_W-1:0]    vlan_tag,
  input  logic [pffwl_pkg::TICK_W-1:0]    now_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            drop,
  output logic [pffwl_pkg::STATUS_W-1:0]  status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pffwl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pffwl_pkg::WINDOW_W-1:0]  cfg_data
);
  import pffwl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  logic [WINDOW_W-1:0] window_ticks;
  logic [COUNT_W-1:0]  max_packets;
  tok_t                chain [0:TABLE_ENTRIES];
  tok_t                pend;
  alloc_t              alloc;
  logic                finish_fire;
  logic                res_drop;
  logic [STATUS_W-1:0] res_status;
  logic                bad_vlan;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      max_packets  <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_TICKS: window_ticks <= cfg_data;
        REG_MAX_PACKETS:  max_packets  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Head of the row: a fresh token loaded when an input is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].active <= 1'b0;
    end else begin
      chain[0].active    <= in_valid && in_ready;
      chain[0].found     <= 1'b0;
      chain[0].free_seen <= 1'b0;
      chain[0].free_idx  <= '0;
      chain[0].port      <= port_id;
      chain[0].vlan      <= vlan_tag;
      chain[0].now       <= now_ticks;
      chain[0].drop      <= 1'b0;
      chain[0].status    <= ST_PASS;
    end
  end

  // Row of slot cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pffwl_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cell_idx     (IDX_W'(i)),
      .window_ticks (window_ticks),
      .max_packets  (max_packets),
      .alloc        (alloc),
      .tok_in       (chain[i]),
      .tok_out      (chain[i+1])
    );
  end

  // Final decision for a token that left the row, and allocation on a miss.
  always_comb begin
    finish_fire = (state == S_FINISH) && (!out_valid || out_ready);
    bad_vlan    = (pend.vlan == VLAN_NONE) || (pend.vlan == VLAN_RESERVED);
    alloc.idx   = pend.free_idx;
    alloc.port  = pend.port;
    alloc.vlan  = pend.vlan;
    alloc.now   = pend.now;
    alloc.en    = 1'b0;
    if (pend.found) begin
      res_drop   = pend.drop;
      res_status = pend.status;
    end else if (bad_vlan) begin
      res_drop   = 1'b1;
      res_status = ST_BAD_VLAN;
    end else if (!pend.free_seen) begin
      res_drop   = 1'b1;
      res_status = ST_FULL;
    end else begin
      alloc.en   = finish_fire;
      res_drop   = (max_packets <= COUNT_W'(1));
      res_status = res_drop ? ST_LIMIT : ST_PASS;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[TABLE_ENTRIES].active) begin
            pend  <= chain[TABLE_ENTRIES];
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish_fire) begin
            drop   <= res_drop;
            status <= res_status;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A token leaves the row only while the sequencer waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[TABLE_ENTRIES].active |-> (state == S_SCAN))
    else $error("lookup token left the row outside the scan state");

  // An accepted input blocks the next one until its result is issued.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a lookup is in progress");

  // Allocation only on a miss with a free slot and a valid VLAN.
  a_alloc_legal: assert property (@(posedge clk) disable iff (rst)
    alloc.en |-> (!pend.found && pend.free_seen && !bad_vlan))
    else $error("slot allocated for a hit, a full table or an invalid VLAN");

  // No token is in the row while the block waits for input.
  a_head_idle: assert property (@(posedge clk) disable iff (rst)
    chain[0].active |-> (state == S_SCAN))
    else $error("token injected without a pending lookup");

  // A result is issued exactly when the finish step fires.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> out_valid)
    else $error("finished lookup did not produce a result");

endmodule

// ===== hw/rtl/pffwl_cell.sv =====
// One flow slot of the limiter: holds the entry and passes the lookup token on.
`timescale 1ns / 1ps
module pffwl_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pffwl_pkg::IDX_W-1:0]    cell_idx,
  input  logic [pffwl_pkg::WINDOW_W-1:0] window_ticks,
  input  logic [pffwl_pkg::COUNT_W-1:0]  max_packets,
  input  pffwl_pkg::alloc_t              alloc,
  input  pffwl_pkg::tok_t                tok_in,
  output pffwl_pkg::tok_t                tok_out
);
  import pffwl_pkg::*;

  // Slot contents.
  logic               valid;
  logic [PORT_W-1:0]  port;
  logic [VLAN_W-1:0]  vlan;
  logic [COUNT_W-1:0] count;
  logic [TICK_W-1:0]  start;

  logic               match;
  logic               claim_free;
  logic [TICK_W-1:0]  diff;
  logic               restart;
  logic [COUNT_W-1:0] cnt_base;
  logic [COUNT_W-1:0] cnt_new;
  logic               alloc_hit;

  // Lookup against this slot and the window update on a hit.
  always_comb begin
    match      = tok_in.active && !tok_in.found && valid &&
                 (port == tok_in.port) && (vlan == tok_in.vlan);
    claim_free = tok_in.active && !tok_in.found && !valid && !tok_in.free_seen;
    diff       = start + TICK_W'(window_ticks) - tok_in.now;
    restart    = diff[TICK_W-1];
    cnt_base   = restart ? '0 : count;
    cnt_new    = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + COUNT_W'(1);
    alloc_hit  = alloc.en && (alloc.idx == cell_idx);
  end

  // Slot state: cleared valid bit at reset, entry written on a hit or allocation.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (alloc_hit) begin
      valid <= 1'b1;
      port  <= alloc.port;
      vlan  <= alloc.vlan;
      count <= COUNT_W'(1);
      start <= alloc.now;
    end else if (match) begin
      count <= cnt_new;
      if (restart) begin
        start <= tok_in.now;
      end
    end
  end

  // Token stage handed to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (match) begin
        tok_out.found  <= 1'b1;
        tok_out.drop   <= (cnt_new >= max_packets);
        tok_out.status <= (cnt_new >= max_packets) ? ST_LIMIT : ST_PASS;
      end else if (claim_free) begin
        tok_out.free_seen <= 1'b1;
        tok_out.free_idx  <= cell_idx;
      end
    end
  end

endmodule
